// File: hdl/csvp_pkg.sv
// ----------------------------------------------------------------------------
// csvp_pkg
// Shared types, character codes and sizes for the CSV integer field parser.
// ----------------------------------------------------------------------------
package csvp_pkg;

  localparam int MAX_COLUMNS = 64;
  localparam int COL_W       = $clog2(MAX_COLUMNS + 1);
  localparam int COL_OUT_W   = 6;
  localparam int BYTE_W      = 8;
  localparam int VALUE_W     = 32;
  localparam int KIND_W      = 3;
  localparam int TDATA_OUT_W = 48;

  localparam logic [BYTE_W-1:0] CHAR_NL    = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_COMMA = 8'h2C;
  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_VT    = 8'h0B;
  localparam logic [BYTE_W-1:0] CHAR_FF    = 8'h0C;
  localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

  typedef enum logic [KIND_W-1:0] {
    KIND_NAME_BYTE    = 3'd0,
    KIND_NAME_END     = 3'd1,
    KIND_VALUE        = 3'd2,
    KIND_EARLY_END    = 3'd3,
    KIND_COL_OVERFLOW = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_DATA   = 2'd1
  } phase_t;

  typedef enum logic [1:0] {
    NS_BLANK  = 2'd0,
    NS_DIGITS = 2'd1,
    NS_DONE   = 2'd2
  } num_stage_t;

  typedef struct packed {
    logic feed;
    logic clear;
  } num_ctrl_t;

endpackage

// File: hdl/csv_integer_field_parser.sv
// ----------------------------------------------------------------------------
// csv_integer_field_parser
// Streaming CSV reader: passes header names out byte by byte, then converts
// each data field to a saturated signed 32-bit integer.
//
//   channel  dir  tdata (low bit up)                    tuser  tlast
//   s_axis   in   data_byte[7:0]                        -      end_of_file
//   m_axis   out  column[5:0] value[37:6] name[45:38]   kind   row_end
//
// One byte per cycle sustained while the receiver takes each result; a byte
// transfer sits in the input register, is parsed, and its result lands in
// the result register.
// The single parse stage updates phase, column counters and the number
// accumulator together, which sets the rate.
// rst is synchronous and returns the parser to header phase with counts zero.
// A held result stalls the input register; an empty input register can still
// take one byte while the result register waits.
// ----------------------------------------------------------------------------
module csv_integer_field_parser (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [csvp_pkg::BYTE_W-1:0]          s_axis_tdata,  // data_byte
  input  logic                                 s_axis_tlast,  // end_of_file
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [csvp_pkg::TDATA_OUT_W-1:0]     m_axis_tdata,  // column, value, name_byte
  output logic [csvp_pkg::KIND_W-1:0]          m_axis_tuser,  // kind
  output logic                                 m_axis_tlast   // row_end
);

  localparam int COL_W = csvp_pkg::COL_W;
  localparam logic [COL_W-1:0] COL_MAX = COL_W'(csvp_pkg::MAX_COLUMNS);

  logic                         in_valid;
  logic [csvp_pkg::BYTE_W-1:0]  in_byte;
  logic                         in_eof;
  logic                         advance;

  csvp_pkg::phase_t             phase;
  csvp_pkg::phase_t             phase_next;
  logic [COL_W-1:0]             column_count;
  logic [COL_W-1:0]             column_count_next;
  logic [COL_W-1:0]             current_column;
  logic [COL_W-1:0]             current_column_next;
  logic [COL_W-1:0]             column_step;

  csvp_pkg::num_ctrl_t          num_ctrl;
  logic signed [csvp_pkg::VALUE_W-1:0] field_value;

  logic                         res_valid;
  csvp_pkg::kind_t              res_kind;
  logic signed [csvp_pkg::VALUE_W-1:0] res_value;
  logic [csvp_pkg::BYTE_W-1:0]  res_name;
  logic                         res_row;
  logic [COL_W+csvp_pkg::COL_OUT_W-1:0] column_wide;

  logic                         out_valid;
  csvp_pkg::kind_t              out_kind;
  logic [csvp_pkg::COL_OUT_W-1:0] out_column;
  logic signed [csvp_pkg::VALUE_W-1:0] out_value;
  logic [csvp_pkg::BYTE_W-1:0]  out_name;
  logic                         out_row;

  logic                         is_delim;
  logic                         is_nl;
  logic                         over;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
      in_eof  <= s_axis_tlast;
    end
  end

  csvp_number u_number (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (num_ctrl),
    .data_byte (in_byte),
    .value     (field_value)
  );

  always_comb begin
    is_delim    = (in_byte == csvp_pkg::CHAR_COMMA) || (in_byte == csvp_pkg::CHAR_NL);
    is_nl       = (in_byte == csvp_pkg::CHAR_NL);
    over        = (current_column >= COL_MAX);
    column_step = over ? current_column : current_column + COL_W'(1);
    column_wide = {{csvp_pkg::COL_OUT_W{1'b0}}, current_column};

    phase_next          = phase;
    column_count_next   = column_count;
    current_column_next = current_column;
    num_ctrl            = '0;
    res_valid           = 1'b0;
    res_kind            = csvp_pkg::KIND_NAME_BYTE;
    res_value           = '0;
    res_name            = '0;
    res_row             = 1'b0;

    if (advance) begin
      if (in_eof) begin
        res_valid           = (phase != csvp_pkg::PH_DATA);
        res_kind            = csvp_pkg::KIND_EARLY_END;
        phase_next          = csvp_pkg::PH_HEADER;
        column_count_next   = '0;
        current_column_next = '0;
        num_ctrl.clear      = 1'b1;
      end else if (phase != csvp_pkg::PH_DATA) begin
        res_valid = 1'b1;
        if (!is_delim) begin
          res_kind = over ? csvp_pkg::KIND_COL_OVERFLOW : csvp_pkg::KIND_NAME_BYTE;
          res_name = over ? '0 : in_byte;
        end else begin
          res_kind = over ? csvp_pkg::KIND_COL_OVERFLOW : csvp_pkg::KIND_NAME_END;
          res_row  = is_nl;
          if (!over) begin
            column_count_next = current_column + COL_W'(1);
          end
          current_column_next = column_step;
          if (is_nl) begin
            phase_next          = csvp_pkg::PH_DATA;
            current_column_next = '0;
            num_ctrl.clear      = 1'b1;
          end
        end
      end else begin
        if (!is_delim) begin
          num_ctrl.feed = 1'b1;
        end else begin
          res_valid = 1'b1;
          res_row   = is_nl;
          if (current_column >= column_count) begin
            res_kind = csvp_pkg::KIND_COL_OVERFLOW;
          end else begin
            res_kind  = csvp_pkg::KIND_VALUE;
            res_value = field_value;
          end
          num_ctrl.clear      = 1'b1;
          current_column_next = is_nl ? '0 : column_step;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= csvp_pkg::PH_HEADER;
      column_count   <= '0;
      current_column <= '0;
      out_valid      <= 1'b0;
    end else begin
      phase          <= phase_next;
      column_count   <= column_count_next;
      current_column <= current_column_next;
      if (advance) begin
        out_valid <= res_valid;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_kind   <= res_kind;
      out_column <= column_wide[csvp_pkg::COL_OUT_W-1:0];
      out_value  <= res_value;
      out_name   <= res_name;
      out_row    <= res_row;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_name, out_value, out_column};
  assign m_axis_tuser  = out_kind;
  assign m_axis_tlast  = out_row;

  a_column_bound: assert property (@(posedge clk) disable iff (rst)
    current_column <= COL_MAX)
    else $error("current column beyond limit");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    column_count <= COL_MAX)
    else $error("column count beyond limit");

  a_eof_restart: assert property (@(posedge clk) disable iff (rst)
    (advance && in_eof) |=> (phase == csvp_pkg::PH_HEADER && current_column == '0))
    else $error("end of file did not restart the parser");

  a_name_byte_no_row: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == csvp_pkg::KIND_NAME_BYTE) |-> !m_axis_tlast)
    else $error("name byte marked as row end");

  a_early_end_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == csvp_pkg::KIND_EARLY_END)
      |-> (out_value == '0 && out_name == '0 && !m_axis_tlast))
    else $error("early end result carries payload");

endmodule

// File: hdl/csvp_number.sv
// ----------------------------------------------------------------------------
// csvp_number
// Decimal field accumulator: skips leading blanks, takes one sign, gathers
// digits with saturation and presents the signed 32-bit field value.
// ----------------------------------------------------------------------------
module csvp_number (
  input  logic                                clk,
  input  logic                                rst,
  input  csvp_pkg::num_ctrl_t                 ctrl,
  input  logic [csvp_pkg::BYTE_W-1:0]         data_byte,
  output logic signed [csvp_pkg::VALUE_W-1:0] value
);

  localparam logic [csvp_pkg::VALUE_W-1:0] MAG_LIMIT = 32'h8000_0000;
  localparam logic [csvp_pkg::VALUE_W-1:0] POS_MAX   = 32'h7FFF_FFFF;

  logic [csvp_pkg::VALUE_W-1:0] accumulator;
  logic [csvp_pkg::VALUE_W-1:0] accumulator_next;
  logic                         negative_sign;
  logic                         negative_sign_next;
  csvp_pkg::num_stage_t         number_stage;
  csvp_pkg::num_stage_t         number_stage_next;

  logic                         is_digit;
  logic                         is_blank;
  logic                         is_sign;
  logic [3:0]                   digit;
  logic [csvp_pkg::VALUE_W+3:0] product;
  logic [csvp_pkg::VALUE_W-1:0] acc_step;

  always_comb begin
    is_digit = (data_byte >= csvp_pkg::CHAR_ZERO) && (data_byte <= csvp_pkg::CHAR_NINE);
    is_blank = data_byte inside {csvp_pkg::CHAR_SPACE, csvp_pkg::CHAR_TAB, csvp_pkg::CHAR_CR,
                                 csvp_pkg::CHAR_VT, csvp_pkg::CHAR_FF};
    is_sign  = (data_byte == csvp_pkg::CHAR_PLUS) || (data_byte == csvp_pkg::CHAR_MINUS);
    digit    = 4'(data_byte - csvp_pkg::CHAR_ZERO);
    product  = {1'b0, accumulator, 3'b000} + {3'b000, accumulator, 1'b0} + {32'd0, digit};
    acc_step = (product > {4'd0, MAG_LIMIT}) ? MAG_LIMIT : product[csvp_pkg::VALUE_W-1:0];
  end

  always_comb begin
    accumulator_next   = accumulator;
    negative_sign_next = negative_sign;
    number_stage_next  = number_stage;
    if (ctrl.clear) begin
      accumulator_next   = '0;
      negative_sign_next = 1'b0;
      number_stage_next  = csvp_pkg::NS_BLANK;
    end else if (ctrl.feed) begin
      case (number_stage)
        csvp_pkg::NS_BLANK: begin
          if (is_blank) begin
            number_stage_next = csvp_pkg::NS_BLANK;
          end else if (is_sign) begin
            negative_sign_next = (data_byte == csvp_pkg::CHAR_MINUS);
            number_stage_next  = csvp_pkg::NS_DIGITS;
          end else if (is_digit) begin
            accumulator_next  = acc_step;
            number_stage_next = csvp_pkg::NS_DIGITS;
          end else begin
            number_stage_next = csvp_pkg::NS_DONE;
          end
        end
        csvp_pkg::NS_DIGITS: begin
          if (is_digit) begin
            accumulator_next = acc_step;
          end else begin
            number_stage_next = csvp_pkg::NS_DONE;
          end
        end
        default: begin
          number_stage_next = number_stage;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator   <= '0;
      negative_sign <= 1'b0;
      number_stage  <= csvp_pkg::NS_BLANK;
    end else begin
      accumulator   <= accumulator_next;
      negative_sign <= negative_sign_next;
      number_stage  <= number_stage_next;
    end
  end

  always_comb begin
    if (negative_sign) begin
      value = signed'(~accumulator + 32'd1);
    end else if (accumulator > POS_MAX) begin
      value = signed'(POS_MAX);
    end else begin
      value = signed'(accumulator);
    end
  end

endmodule

// File: dv/csv_integer_field_parser_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csv_integer_field_parser_checker
// Follows every byte transfer into the parser and works out the result it
// should give: name bytes and name ends in the header, saturated atoi values
// in the data rows, column overflows and early ends of file. Matches each
// result transfer against the oldest outstanding prediction, field by field.
// ----------------------------------------------------------------------------
module csv_integer_field_parser_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  input  logic [csvp_pkg::BYTE_W-1:0]      s_axis_tdata,   // data_byte
  input  logic                             s_axis_tlast,   // end_of_file
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic [csvp_pkg::TDATA_OUT_W-1:0] m_axis_tdata,   // column, value, name_byte
  input  logic [csvp_pkg::KIND_W-1:0]      m_axis_tuser,   // kind
  input  logic                             m_axis_tlast,   // row_end
  output int                               fail_count,
  output int                               pending,
  output int                               results_seen
);

  localparam int COL_OUT_W   = csvp_pkg::COL_OUT_W;
  localparam int VALUE_W     = csvp_pkg::VALUE_W;
  localparam int BYTE_W      = csvp_pkg::BYTE_W;
  localparam int TDATA_OUT_W = csvp_pkg::TDATA_OUT_W;
  localparam int VAL_LSB     = COL_OUT_W;
  localparam int NAME_LSB    = VAL_LSB + VALUE_W;
  localparam int PAD_LSB     = NAME_LSB + BYTE_W;
  localparam longint unsigned MAG_CAP = 64'h8000_0000;

  typedef struct {
    csvp_pkg::kind_t      kind;
    logic [COL_OUT_W-1:0] column;
    logic [VALUE_W-1:0]   value;
    logic [BYTE_W-1:0]    name;
    logic                 row_end;
  } field_result_t;

  csvp_pkg::phase_t     phase;
  int                   col_count;
  int                   cur_col;
  longint unsigned      acc;
  bit                   neg;
  csvp_pkg::num_stage_t stage;

  field_result_t due_results[$];
  int            errs = 0;
  int            n_results = 0;

  assign fail_count = errs;

  task automatic flag_mismatch(input string what);
    errs++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic clear_number();
    acc   = 0;
    neg   = 1'b0;
    stage = csvp_pkg::NS_BLANK;
  endtask

  task automatic bump_column();
    if (cur_col < csvp_pkg::MAX_COLUMNS) cur_col++;
  endtask

  task automatic parse_byte(input logic [BYTE_W-1:0] b, input logic eof,
                            output bit fired, output field_result_t r);
    bit              delim;
    bit              nl;
    bit              over;
    bit              digit;
    bit              blank;
    bit              take;
    longint unsigned mag;
    delim     = (b == csvp_pkg::CHAR_COMMA) || (b == csvp_pkg::CHAR_NL);
    nl        = (b == csvp_pkg::CHAR_NL);
    digit     = (b >= csvp_pkg::CHAR_ZERO) && (b <= csvp_pkg::CHAR_NINE);
    blank     = b inside {csvp_pkg::CHAR_SPACE, csvp_pkg::CHAR_TAB, csvp_pkg::CHAR_CR,
                          csvp_pkg::CHAR_VT, csvp_pkg::CHAR_FF};
    take      = 1'b0;
    fired     = 1'b0;
    r.kind    = csvp_pkg::KIND_NAME_BYTE;
    r.column  = cur_col[COL_OUT_W-1:0];
    r.value   = '0;
    r.name    = '0;
    r.row_end = 1'b0;
    if (eof) begin
      if (phase != csvp_pkg::PH_DATA) begin
        fired  = 1'b1;
        r.kind = csvp_pkg::KIND_EARLY_END;
      end
      phase     = csvp_pkg::PH_HEADER;
      col_count = 0;
      cur_col   = 0;
      clear_number();
    end else if (phase != csvp_pkg::PH_DATA) begin
      over  = (cur_col >= csvp_pkg::MAX_COLUMNS);
      fired = 1'b1;
      if (!delim) begin
        r.kind = over ? csvp_pkg::KIND_COL_OVERFLOW : csvp_pkg::KIND_NAME_BYTE;
        r.name = over ? '0 : b;
      end else begin
        r.kind    = over ? csvp_pkg::KIND_COL_OVERFLOW : csvp_pkg::KIND_NAME_END;
        r.row_end = nl;
        if (!over) col_count = cur_col + 1;
        bump_column();
        if (nl) begin
          phase   = csvp_pkg::PH_DATA;
          cur_col = 0;
          clear_number();
        end
      end
    end else if (!delim) begin
      case (stage)
        csvp_pkg::NS_BLANK: begin
          if (b == csvp_pkg::CHAR_PLUS || b == csvp_pkg::CHAR_MINUS) begin
            neg   = (b == csvp_pkg::CHAR_MINUS);
            stage = csvp_pkg::NS_DIGITS;
          end else if (digit) begin
            stage = csvp_pkg::NS_DIGITS;
            take  = 1'b1;
          end else if (!blank) begin
            stage = csvp_pkg::NS_DONE;
          end
        end
        csvp_pkg::NS_DIGITS: begin
          if (digit) take = 1'b1;
          else stage = csvp_pkg::NS_DONE;
        end
        default: ;
      endcase
      if (take) begin
        acc = acc * 10 + 64'(b - csvp_pkg::CHAR_ZERO);
        if (acc > MAG_CAP) acc = MAG_CAP;
      end
    end else begin
      fired     = 1'b1;
      r.row_end = nl;
      if (cur_col >= col_count) begin
        r.kind = csvp_pkg::KIND_COL_OVERFLOW;
      end else begin
        r.kind = csvp_pkg::KIND_VALUE;
        if (neg) begin
          mag = (acc > MAG_CAP) ? MAG_CAP : acc;
          mag = -mag;
        end else begin
          mag = (acc > MAG_CAP - 1) ? MAG_CAP - 1 : acc;
        end
        r.value = mag[VALUE_W-1:0];
      end
      clear_number();
      if (nl) cur_col = 0;
      else bump_column();
    end
  endtask

  always @(posedge clk) begin : watch
    field_result_t want;
    field_result_t guess;
    bit            fired;
    if (rst) begin
      phase     = csvp_pkg::PH_HEADER;
      col_count = 0;
      cur_col   = 0;
      clear_number();
      due_results.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_results++;
        if (due_results.size() == 0) begin
          flag_mismatch($sformatf("unexpected result kind %0d column %0d",
                                  m_axis_tuser, m_axis_tdata[COL_OUT_W-1:0]));
        end else begin
          want = due_results.pop_front();
          if (m_axis_tuser !== want.kind)
            flag_mismatch($sformatf("kind %0d, want %0d", m_axis_tuser, want.kind));
          if (m_axis_tdata[COL_OUT_W-1:0] !== want.column)
            flag_mismatch($sformatf("column %0d, want %0d",
                                    m_axis_tdata[COL_OUT_W-1:0], want.column));
          if (m_axis_tdata[NAME_LSB-1:VAL_LSB] !== want.value)
            flag_mismatch($sformatf("value %0d, want %0d",
                                    $signed(m_axis_tdata[NAME_LSB-1:VAL_LSB]),
                                    $signed(want.value)));
          if (m_axis_tdata[PAD_LSB-1:NAME_LSB] !== want.name)
            flag_mismatch($sformatf("name byte %02h, want %02h",
                                    m_axis_tdata[PAD_LSB-1:NAME_LSB], want.name));
          if (m_axis_tlast !== want.row_end)
            flag_mismatch($sformatf("row end %b, want %b", m_axis_tlast, want.row_end));
          if (m_axis_tdata[TDATA_OUT_W-1:PAD_LSB] !== '0)
            flag_mismatch($sformatf("padding bits %b not zero",
                                    m_axis_tdata[TDATA_OUT_W-1:PAD_LSB]));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        parse_byte(s_axis_tdata, s_axis_tlast, fired, guess);
        if (fired) due_results.push_back(guess);
      end
    end
    pending      <= due_results.size();
    results_seen <= n_results;
  end

endmodule

// File: dv/csv_integer_field_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csv_integer_field_parser_tb
// Feeds the parser whole CSV files, mostly well formed with random names and
// numbers, plus broken headers, surplus columns, junk and early end of file.
// Runs through several mixes of sender gaps and receiver stalls; the checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module csv_integer_field_parser_tb;

  localparam int BYTE_W       = csvp_pkg::BYTE_W;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_BYTES = 480;
  localparam int SETTLE       = 20;

  localparam logic [BYTE_W-1:0] CHAR_NL    = csvp_pkg::CHAR_NL;
  localparam logic [BYTE_W-1:0] CHAR_COMMA = csvp_pkg::CHAR_COMMA;
  localparam logic [BYTE_W-1:0] CHAR_PLUS  = csvp_pkg::CHAR_PLUS;
  localparam logic [BYTE_W-1:0] CHAR_MINUS = csvp_pkg::CHAR_MINUS;
  localparam logic [BYTE_W-1:0] CHAR_ZERO  = csvp_pkg::CHAR_ZERO;

  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 s_axis_tvalid = 1'b0;
  logic                                 s_axis_tready;
  logic [BYTE_W-1:0]                    s_axis_tdata = '0;   // data_byte
  logic                                 s_axis_tlast = 1'b0; // end_of_file
  logic                                 m_axis_tvalid;
  logic                                 m_axis_tready = 1'b0;
  logic [csvp_pkg::TDATA_OUT_W-1:0]     m_axis_tdata;        // column, value, name_byte
  logic [csvp_pkg::KIND_W-1:0]          m_axis_tuser;        // kind
  logic                                 m_axis_tlast;        // row_end

  int fail_count;
  int pending;
  int results_seen;
  int send_idle  = 0;
  int stall_pct  = 0;
  int hold_req   = 0;
  int hold_seen  = 0;
  int hold_left  = 0;
  int bytes_sent = 0;
  int files_sent = 0;

  csv_integer_field_parser uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  csv_integer_field_parser_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count    (fail_count),
    .pending       (pending),
    .results_seen  (results_seen)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // hold off for a long stretch on request, otherwise stall at random
  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen     <= hold_req;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [BYTE_W-1:0] name_char();
    logic [BYTE_W-1:0] c;
    c = 8'($urandom_range(255));
    while (c == CHAR_COMMA || c == CHAR_NL) c = 8'($urandom_range(255));
    return c;
  endfunction

  task automatic push_byte(input logic [BYTE_W-1:0] b, input logic eof);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eof;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], 1'b0);
  endtask

  // drop valid and wait for every outstanding result
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic push_field();
    logic [BYTE_W-1:0] blanks [5] = '{csvp_pkg::CHAR_SPACE, csvp_pkg::CHAR_TAB,
                                      csvp_pkg::CHAR_CR, csvp_pkg::CHAR_VT,
                                      csvp_pkg::CHAR_FF};
    int len;
    case ($urandom_range(19))
      0: repeat ($urandom_range(1, 3)) push_byte(name_char(), 1'b0);
      1: begin
        if ($urandom_range(1) == 0) push_byte(CHAR_MINUS, 1'b0);
        push_text("214748364");
        push_byte(8'(CHAR_ZERO + $urandom_range(6, 9)), 1'b0);
      end
      default: begin
        repeat ($urandom_range(0, 2)) push_byte(blanks[$urandom_range(4)], 1'b0);
        case ($urandom_range(3))
          0: push_byte(CHAR_PLUS, 1'b0);
          1: push_byte(CHAR_MINUS, 1'b0);
          default: ;
        endcase
        len = ($urandom_range(7) == 0) ? $urandom_range(10, 13) : $urandom_range(0, 4);
        repeat (len) push_byte(8'(CHAR_ZERO + $urandom_range(9)), 1'b0);
        if ($urandom_range(5) == 0) begin
          push_byte(name_char(), 1'b0);
          push_byte(8'(CHAR_ZERO + $urandom_range(9)), 1'b0);
        end
      end
    endcase
  endtask

  task automatic push_file(input int ncols, input int rows);
    int cut;
    int nfields;
    cut = ($urandom_range(9) == 0) ? $urandom_range(0, ncols - 1) : -1;
    for (int c = 0; c < ncols; c++) begin
      repeat ($urandom_range(0, 3)) push_byte(name_char(), 1'b0);
      if (c == cut) begin
        push_byte(8'($urandom_range(255)), 1'b1);
        files_sent++;
        return;
      end
      push_byte((c == ncols - 1) ? CHAR_NL : CHAR_COMMA, 1'b0);
    end
    for (int r = 0; r < rows; r++) begin
      nfields = ncols;
      case ($urandom_range(9))
        0: nfields = ncols + $urandom_range(1, 2);
        1: nfields = $urandom_range(1, ncols);
        default: ;
      endcase
      for (int f = 0; f < nfields; f++) begin
        push_field();
        push_byte((f == nfields - 1) ? CHAR_NL : CHAR_COMMA, 1'b0);
      end
    end
    if ($urandom_range(5) == 0)
      repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(255)), 1'b0);
    if ($urandom_range(4) == 0) push_field();
    push_byte(8'($urandom_range(255)), 1'b1);
    files_sent++;
  endtask

  initial begin
    int base;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // header with a 0xFF name byte, saturating negative, sign with junk,
    // empty fields and a surplus column, then both kinds of end of file
    push_text("a,");
    push_byte(8'hFF, 1'b0);
    push_byte(CHAR_NL, 1'b0);
    push_text("-9999999999,+3x\n");
    push_text(",,\n");
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b1);
    settle();

    for (int ph = 0; ph < 4; ph++) begin
      base = bytes_sent;
      case (ph)
        0: begin
          send_idle = 0;
          stall_pct <= 0;
          hold_req  <= hold_req + 1;
        end
        1: begin
          send_idle = 48;
          stall_pct <= 0;
        end
        2: begin
          send_idle = 0;
          stall_pct <= 48;
        end
        default: begin
          send_idle = 10;
          stall_pct <= 10;
        end
      endcase
      if (ph == 1) push_file(68, 0);
      while (bytes_sent < base + RANDOM_BYTES / 4)
        push_file($urandom_range(1, 6), $urandom_range(1, 4));
      settle();
    end

    repeat (SETTLE) @(posedge clk);
    $display("Sent %0d byte transfers in %0d files and checked %0d results.",
             bytes_sent, files_sent, results_seen);
    $display("Covered four gap/stall mixes, saturation edges, signs and blanks,");
    $display("surplus and 64+ columns, and early end of file.");
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/csvp_pkg.sv
hdl/csvp_number.sv
hdl/csv_integer_field_parser.sv
dv/csv_integer_field_parser_checker.sv
dv/csv_integer_field_parser_tb.sv
